### src/lgfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgfs_pkg
// shared types and constants of the led group fade sequencer
// ----------------------------------------------------------------------------
package lgfs_pkg;

	// item operation codes
	typedef enum logic {
		OP_SET  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// light mode codes
	typedef enum logic {
		MODE_WHITE = 1'b0,
		MODE_COLOR = 1'b1
	} mode_t;

	localparam int unsigned NUM_CH  = 5;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned PROD_W  = 2 * PCT_W;
	localparam int unsigned DUTY_W  = 10;

	// channel slots
	localparam logic [2:0] CH_RED   = 3'd0;
	localparam logic [2:0] CH_GREEN = 3'd1;
	localparam logic [2:0] CH_BLUE  = 3'd2;
	localparam logic [2:0] CH_COOL  = 3'd3;
	localparam logic [2:0] CH_WARM  = 3'd4;

	// largest value a duty field can carry
	localparam logic [DUTY_W-1:0] DUTY_SAT = '1;

	// percent ceiling for level and temperature
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	// floor(p*255/10000) == (p*SCALE_MUL) >> SCALE_SHIFT for p <= 10000
	localparam int unsigned      SCALE_SHIFT = 25;
	localparam int unsigned      SCALE_W     = 20;
	localparam logic [SCALE_W-1:0] SCALE_MUL = 20'd855639;

endpackage

### src/led_group_fade_sequencer_core.sv
`timescale 1ns / 1ps
// path: an accepted item passes the s1, channel state (s2) and result registers
// throughput: one item per cycle while the output is not stalled, set by the
// state update loop (levels and targets are read and written back together)
// reset: arst_n clears levels, targets, mode and all valid flags at once;
// the block takes items from the first clock edge after reset release
// ----------------------------------------------------------------------------
// led_group_fade_sequencer_core
// five-channel led fader: set items load targets, tick items step the levels,
// every item returns the five pwm duties and a busy flag
// ----------------------------------------------------------------------------
module led_group_fade_sequencer_core #(
	parameter int unsigned DUTY_MAX = 999
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// item input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic                         color_mode,
	input  logic [lgfs_pkg::LEVEL_W-1:0] red_target,
	input  logic [lgfs_pkg::LEVEL_W-1:0] green_target,
	input  logic [lgfs_pkg::LEVEL_W-1:0] blue_target,
	input  logic [lgfs_pkg::PCT_W-1:0]   white_level,
	input  logic [lgfs_pkg::PCT_W-1:0]   white_temp,
	// result output channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lgfs_pkg::DUTY_W-1:0]  red_duty,
	output logic [lgfs_pkg::DUTY_W-1:0]  green_duty,
	output logic [lgfs_pkg::DUTY_W-1:0]  blue_duty,
	output logic [lgfs_pkg::DUTY_W-1:0]  cool_duty,
	output logic [lgfs_pkg::DUTY_W-1:0]  warm_duty,
	output logic                         fading
);

	localparam int unsigned LW = lgfs_pkg::LEVEL_W;
	localparam int unsigned PW = lgfs_pkg::PCT_W;
	localparam int unsigned XW = lgfs_pkg::PROD_W;
	localparam int unsigned DW = lgfs_pkg::DUTY_W;
	localparam int unsigned NC = lgfs_pkg::NUM_CH;

	// duty = level*DUTY_MAX/255 split into whole and remainder parts
	// so the remainder division stays within 16 bits
	localparam logic [8:0] DUTY_QUO = 9'(DUTY_MAX / 255);
	localparam logic [7:0] DUTY_REM = 8'(DUTY_MAX % 255);

	// ------------------------------------------------------------------
	// pipeline control
	// s1: registered item with the white split products
	// s2: result pending on the channel state registers
	// out: result item register
	// ------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic out_adv;
	logic s2_adv;
	logic in_acc;

	assign out_adv  = !out_valid_q || out_ready;
	assign s2_adv   = !valid_s2 || out_adv;
	assign in_ready = !valid_s1 || s2_adv;
	assign in_acc   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// input side: saturate percentages, form t*l and (100-t)*l
	// ------------------------------------------------------------------
	logic [PW-1:0] lvl_sat;
	logic [PW-1:0] temp_sat;
	logic [PW-1:0] temp_inv;
	logic [XW-1:0] cool_prod;
	logic [XW-1:0] warm_prod;

	always_comb begin
		lvl_sat   = (white_level > lgfs_pkg::PCT_MAX) ? lgfs_pkg::PCT_MAX : white_level;
		temp_sat  = (white_temp > lgfs_pkg::PCT_MAX) ? lgfs_pkg::PCT_MAX : white_temp;
		temp_inv  = lgfs_pkg::PCT_MAX - temp_sat;
		cool_prod = XW'(temp_sat) * XW'(lvl_sat);
		warm_prod = XW'(temp_inv) * XW'(lvl_sat);
	end

	lgfs_pkg::op_t   op_s1;
	lgfs_pkg::mode_t mode_s1;
	logic [LW-1:0]   red_s1;
	logic [LW-1:0]   green_s1;
	logic [LW-1:0]   blue_s1;
	logic [XW-1:0]   cool_prod_s1;
	logic [XW-1:0]   warm_prod_s1;

	// item payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1        <= lgfs_pkg::op_t'(operation);
			mode_s1      <= lgfs_pkg::mode_t'(color_mode);
			red_s1       <= red_target;
			green_s1     <= green_target;
			blue_s1      <= blue_target;
			cool_prod_s1 <= cool_prod;
			warm_prod_s1 <= warm_prod;
		end
	end

	// ------------------------------------------------------------------
	// channel state
	// ------------------------------------------------------------------
	logic [LW-1:0]   level_q  [NC];
	logic [LW-1:0]   target_q [NC];
	lgfs_pkg::mode_t mode_q;

	logic [LW-1:0]   level_nx  [NC];
	logic [LW-1:0]   target_nx [NC];
	logic [NC-1:0]   differs;
	logic [NC-1:0]   is_rgb;
	logic [NC-1:0]   move;
	logic            rgb_busy;
	logic            wht_busy;
	logic            off_busy;
	logic            step_rgb;
	logic            s1_fire;

	logic [XW+lgfs_pkg::SCALE_W-1:0] cool_scaled;
	logic [XW+lgfs_pkg::SCALE_W-1:0] warm_scaled;

	assign s1_fire = valid_s1 && s2_adv;

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			differs[i] = level_q[i] != target_q[i];
			is_rgb[i]  = i < int'(lgfs_pkg::CH_COOL);
		end
		rgb_busy = |(differs & is_rgb);
		wht_busy = |(differs & ~is_rgb);

		// the group being turned off moves first; the active group only
		// once the other one has settled
		off_busy = (mode_q == lgfs_pkg::MODE_COLOR) ? wht_busy : rgb_busy;
		step_rgb = (mode_q == lgfs_pkg::MODE_COLOR) ? !off_busy : off_busy;
		move     = step_rgb ? is_rgb : ~is_rgb;

		// white split: floor(p*255/10000) by reciprocal multiply
		cool_scaled = (XW + lgfs_pkg::SCALE_W)'(cool_prod_s1)
			* (XW + lgfs_pkg::SCALE_W)'(lgfs_pkg::SCALE_MUL);
		warm_scaled = (XW + lgfs_pkg::SCALE_W)'(warm_prod_s1)
			* (XW + lgfs_pkg::SCALE_W)'(lgfs_pkg::SCALE_MUL);

		for (int i = 0; i < NC; i++) begin
			level_nx[i]  = level_q[i];
			target_nx[i] = target_q[i];
		end

		unique case (op_s1)
			lgfs_pkg::OP_SET: begin
				// set item: new targets only, levels keep fading from where they are
				if (mode_s1 == lgfs_pkg::MODE_COLOR) begin
					target_nx[lgfs_pkg::CH_RED]   = red_s1;
					target_nx[lgfs_pkg::CH_GREEN] = green_s1;
					target_nx[lgfs_pkg::CH_BLUE]  = blue_s1;
					target_nx[lgfs_pkg::CH_COOL]  = '0;
					target_nx[lgfs_pkg::CH_WARM]  = '0;
				end else begin
					target_nx[lgfs_pkg::CH_RED]   = '0;
					target_nx[lgfs_pkg::CH_GREEN] = '0;
					target_nx[lgfs_pkg::CH_BLUE]  = '0;
					target_nx[lgfs_pkg::CH_COOL]  =
						cool_scaled[lgfs_pkg::SCALE_SHIFT +: LW];
					target_nx[lgfs_pkg::CH_WARM]  =
						warm_scaled[lgfs_pkg::SCALE_SHIFT +: LW];
				end
			end
			lgfs_pkg::OP_TICK: begin
				// one step toward target on every channel of the chosen group
				for (int i = 0; i < NC; i++) begin
					if (move[i] && level_q[i] < target_q[i]) begin
						level_nx[i] = level_q[i] + 1'b1;
					end else if (move[i] && level_q[i] > target_q[i]) begin
						level_nx[i] = level_q[i] - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				level_q[i]  <= '0;
				target_q[i] <= '0;
			end
			mode_q <= lgfs_pkg::MODE_WHITE;
		end else if (s1_fire) begin
			for (int i = 0; i < NC; i++) begin
				level_q[i]  <= level_nx[i];
				target_q[i] <= target_nx[i];
			end
			if (op_s1 == lgfs_pkg::OP_SET) begin
				mode_q <= mode_s1;
			end
		end
	end

	// ------------------------------------------------------------------
	// result side: duties of the levels that the s2 item left behind
	// (a new item updating the state at the same edge is not yet seen)
	// ------------------------------------------------------------------
	function automatic logic [DW-1:0] duty_of(input logic [LW-1:0] lvl);
		logic [16:0] whole;
		logic [15:0] part;
		logic [16:0] part_div;
		logic [17:0] sum;
		whole    = 17'(lvl) * 17'(DUTY_QUO);
		part     = 16'(lvl) * 16'(DUTY_REM);
		// exact part/255 for any part below 65280
		part_div = 17'(part) + 17'(part[15:8]) + 17'd1;
		sum      = 18'(whole) + 18'(part_div[15:8]);
		return (sum > 18'(lgfs_pkg::DUTY_SAT)) ? lgfs_pkg::DUTY_SAT : sum[DW-1:0];
	endfunction

	logic [DW-1:0] duty_nx [NC];
	logic [DW-1:0] duty_q  [NC];
	logic          fading_q;

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			duty_nx[i] = duty_of(level_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_adv) begin
			for (int i = 0; i < NC; i++) begin
				duty_q[i] <= duty_nx[i];
			end
			fading_q <= |differs;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_adv) begin
				valid_s2 <= valid_s1;
			end
			if (out_adv) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign red_duty   = duty_q[lgfs_pkg::CH_RED];
	assign green_duty = duty_q[lgfs_pkg::CH_GREEN];
	assign blue_duty  = duty_q[lgfs_pkg::CH_BLUE];
	assign cool_duty  = duty_q[lgfs_pkg::CH_COOL];
	assign warm_duty  = duty_q[lgfs_pkg::CH_WARM];
	assign fading     = fading_q;

endmodule

### src/lgfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgfs_checker
// port-level checks of the fade sequencer, bound to the top level
// ----------------------------------------------------------------------------
module lgfs_checker #(
	parameter int unsigned DUTY_MAX = 999
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [lgfs_pkg::DUTY_W-1:0] red_duty,
	input logic [lgfs_pkg::DUTY_W-1:0] green_duty,
	input logic [lgfs_pkg::DUTY_W-1:0] blue_duty,
	input logic [lgfs_pkg::DUTY_W-1:0] cool_duty,
	input logic [lgfs_pkg::DUTY_W-1:0] warm_duty,
	input logic                        fading
);

	localparam logic [lgfs_pkg::DUTY_W-1:0] DUTY_LIM =
		(DUTY_MAX > 1023) ? lgfs_pkg::DUTY_SAT : lgfs_pkg::DUTY_W'(DUTY_MAX);

	// items taken in but not yet delivered
	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_duty)
			&& $stable(green_duty) && $stable(blue_duty) && $stable(cool_duty)
			&& $stable(warm_duty) && $stable(fading))
		else $error("result changed while stalled");

	// a free output never blocks the input side
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is free");

	// every result belongs to an accepted item
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result without a pending item");

	// at most three items in flight
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("too many items in flight");

	// duties stay within the pwm period
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red_duty <= DUTY_LIM && green_duty <= DUTY_LIM
			&& blue_duty <= DUTY_LIM && cool_duty <= DUTY_LIM && warm_duty <= DUTY_LIM)
		else $error("duty above period");

endmodule

bind led_group_fade_sequencer_core lgfs_checker #(.DUTY_MAX(DUTY_MAX)) u_lgfs_checker (.*);

### sim/tb_led_group_fade_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_group_fade_sequencer_core
// self-checking bench for the five-channel fade sequencer: a directed run over
// modes, saturation and fade restarts, then random set and tick items with
// idle bursts on both channels, every result checked against a local model
// ----------------------------------------------------------------------------
module tb_led_group_fade_sequencer_core;

	localparam int unsigned DUTY_MAX    = 999;
	localparam int unsigned RAND_ITEMS  = 900;
	localparam int unsigned QUIET_FROM  = 780;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;

	// one result item as the block reports it
	typedef struct packed {
		logic [lgfs_pkg::DUTY_W-1:0] red;
		logic [lgfs_pkg::DUTY_W-1:0] green;
		logic [lgfs_pkg::DUTY_W-1:0] blue;
		logic [lgfs_pkg::DUTY_W-1:0] cool;
		logic [lgfs_pkg::DUTY_W-1:0] warm;
		logic                        busy;
	} duty_report_t;

	// model of the fader plus the queue of duty reports still owed
	class fade_scoreboard;
		logic [lgfs_pkg::LEVEL_W-1:0] level[lgfs_pkg::NUM_CH];
		logic [lgfs_pkg::LEVEL_W-1:0] target[lgfs_pkg::NUM_CH];
		lgfs_pkg::mode_t              mode;
		duty_report_t                 duty_expect_q[$];
		int unsigned                  err_count;
		int unsigned                  checked;

		function new();
			for (int i = 0; i < lgfs_pkg::NUM_CH; i++) begin
				level[i]  = '0;
				target[i] = '0;
			end
			mode      = lgfs_pkg::MODE_WHITE;
			err_count = 0;
			checked   = 0;
		endfunction

		function logic [lgfs_pkg::DUTY_W-1:0] duty_of(logic [lgfs_pkg::LEVEL_W-1:0] lvl);
			int unsigned d;
			d = (int'(lvl) * DUTY_MAX) / 255;
			if (d > lgfs_pkg::DUTY_SAT)
				d = lgfs_pkg::DUTY_SAT;
			return d[lgfs_pkg::DUTY_W-1:0];
		endfunction

		function bit span_busy(int first, int count);
			for (int i = first; i < first + count; i++)
				if (level[i] != target[i])
					return 1'b1;
			return 1'b0;
		endfunction

		function void span_step(int first, int count);
			for (int i = first; i < first + count; i++) begin
				if (level[i] < target[i])
					level[i] = level[i] + 1'b1;
				else if (level[i] > target[i])
					level[i] = level[i] - 1'b1;
			end
		endfunction

		// note an accepted item and queue the report it causes
		function void note_item(lgfs_pkg::op_t op, lgfs_pkg::mode_t md,
				logic [lgfs_pkg::LEVEL_W-1:0] r, logic [lgfs_pkg::LEVEL_W-1:0] g,
				logic [lgfs_pkg::LEVEL_W-1:0] b, logic [lgfs_pkg::PCT_W-1:0] wl,
				logic [lgfs_pkg::PCT_W-1:0] wt);
			int unsigned  l;
			int unsigned  t;
			int           off_first;
			int           off_count;
			duty_report_t rep;
			if (op == lgfs_pkg::OP_SET) begin
				if (md == lgfs_pkg::MODE_COLOR) begin
					target[lgfs_pkg::CH_RED]   = r;
					target[lgfs_pkg::CH_GREEN] = g;
					target[lgfs_pkg::CH_BLUE]  = b;
					target[lgfs_pkg::CH_COOL]  = '0;
					target[lgfs_pkg::CH_WARM]  = '0;
				end else begin
					l = (wl > lgfs_pkg::PCT_MAX) ? lgfs_pkg::PCT_MAX : wl;
					t = (wt > lgfs_pkg::PCT_MAX) ? lgfs_pkg::PCT_MAX : wt;
					target[lgfs_pkg::CH_RED]   = '0;
					target[lgfs_pkg::CH_GREEN] = '0;
					target[lgfs_pkg::CH_BLUE]  = '0;
					target[lgfs_pkg::CH_COOL]  =
						(lgfs_pkg::LEVEL_W)'((t * l * 255) / 10000);
					target[lgfs_pkg::CH_WARM]  =
						(lgfs_pkg::LEVEL_W)'(((100 - t) * l * 255) / 10000);
				end
				mode = md;
			end else begin
				off_first = (mode == lgfs_pkg::MODE_COLOR) ? lgfs_pkg::CH_COOL
					: lgfs_pkg::CH_RED;
				off_count = (mode == lgfs_pkg::MODE_COLOR) ? 2 : 3;
				if (span_busy(off_first, off_count))
					span_step(off_first, off_count);
				else if (mode == lgfs_pkg::MODE_COLOR)
					span_step(lgfs_pkg::CH_RED, 3);
				else
					span_step(lgfs_pkg::CH_COOL, 2);
			end
			rep.red   = duty_of(level[lgfs_pkg::CH_RED]);
			rep.green = duty_of(level[lgfs_pkg::CH_GREEN]);
			rep.blue  = duty_of(level[lgfs_pkg::CH_BLUE]);
			rep.cool  = duty_of(level[lgfs_pkg::CH_COOL]);
			rep.warm  = duty_of(level[lgfs_pkg::CH_WARM]);
			rep.busy  = span_busy(0, lgfs_pkg::NUM_CH);
			duty_expect_q.push_back(rep);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				err_count++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		// compare one accepted result with the oldest report owed
		function void check_result(duty_report_t got);
			duty_report_t want;
			if (duty_expect_q.size() == 0) begin
				err_count++;
				$display("%0t: result with none expected, actual %h", $time, got);
				return;
			end
			want = duty_expect_q.pop_front();
			checked++;
			compare_field("red_duty", want.red, got.red);
			compare_field("green_duty", want.green, got.green);
			compare_field("blue_duty", want.blue, got.blue);
			compare_field("cool_duty", want.cool, got.cool);
			compare_field("warm_duty", want.warm, got.warm);
			compare_field("fading", want.busy, got.busy);
		endfunction

		function int unsigned pending();
			return duty_expect_q.size();
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic                         operation;
	logic                         color_mode;
	logic [lgfs_pkg::LEVEL_W-1:0] red_target;
	logic [lgfs_pkg::LEVEL_W-1:0] green_target;
	logic [lgfs_pkg::LEVEL_W-1:0] blue_target;
	logic [lgfs_pkg::PCT_W-1:0]   white_level;
	logic [lgfs_pkg::PCT_W-1:0]   white_temp;
	logic                         out_valid;
	logic                         out_ready;
	logic [lgfs_pkg::DUTY_W-1:0]  red_duty;
	logic [lgfs_pkg::DUTY_W-1:0]  green_duty;
	logic [lgfs_pkg::DUTY_W-1:0]  blue_duty;
	logic [lgfs_pkg::DUTY_W-1:0]  cool_duty;
	logic [lgfs_pkg::DUTY_W-1:0]  warm_duty;
	logic                         fading;

	fade_scoreboard sb;
	int unsigned    cycle_count = 0;
	bit             quiet;
	int unsigned    n_tick;
	int unsigned    n_set_color;
	int unsigned    n_set_white;

	led_group_fade_sequencer_core #(
		.DUTY_MAX(DUTY_MAX)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.color_mode  (color_mode),
		.red_target  (red_target),
		.green_target(green_target),
		.blue_target (blue_target),
		.white_level (white_level),
		.white_temp  (white_temp),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red_duty    (red_duty),
		.green_duty  (green_duty),
		.blue_duty   (blue_duty),
		.cool_duty   (cool_duty),
		.warm_duty   (warm_duty),
		.fading      (fading)
	);

	// free-running clock, 2 ns period
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog on the cycle count
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{red_duty, green_duty, blue_duty, cool_duty, warm_duty, fading});
	end

	// result side back-pressure: random stall bursts, none in the quiet tail
	initial begin : ready_driver
		int unsigned stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				out_ready = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_ready  = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// present one item at the falling edge and hold it until accepted
	task automatic send_item(lgfs_pkg::op_t op, lgfs_pkg::mode_t md,
			logic [lgfs_pkg::LEVEL_W-1:0] r, logic [lgfs_pkg::LEVEL_W-1:0] g,
			logic [lgfs_pkg::LEVEL_W-1:0] b, logic [lgfs_pkg::PCT_W-1:0] wl,
			logic [lgfs_pkg::PCT_W-1:0] wt);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid     = 1'b1;
		operation    = op;
		color_mode   = md;
		red_target   = r;
		green_target = g;
		blue_target  = b;
		white_level  = wl;
		white_temp   = wt;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(op, md, r, g, b, wl, wt);
		if (op == lgfs_pkg::OP_TICK)
			n_tick++;
		else if (md == lgfs_pkg::MODE_COLOR)
			n_set_color++;
		else
			n_set_white++;
		@(negedge clk);
	endtask

	// tick with random don't-care payload
	task automatic send_tick();
		send_item(lgfs_pkg::OP_TICK, lgfs_pkg::mode_t'($urandom_range(0, 1)),
			(lgfs_pkg::LEVEL_W)'($urandom), (lgfs_pkg::LEVEL_W)'($urandom),
			(lgfs_pkg::LEVEL_W)'($urandom), (lgfs_pkg::PCT_W)'($urandom),
			(lgfs_pkg::PCT_W)'($urandom));
	endtask

	task automatic send_ticks(int unsigned n);
		repeat (n) send_tick();
	endtask

	// mostly small targets so that fades finish, sometimes the full range
	function automatic logic [lgfs_pkg::LEVEL_W-1:0] pick_target();
		if ($urandom_range(0, 9) < 7)
			return (lgfs_pkg::LEVEL_W)'($urandom_range(0, 20));
		return (lgfs_pkg::LEVEL_W)'($urandom_range(0, 255));
	endfunction

	function automatic logic [lgfs_pkg::PCT_W-1:0] pick_pct();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return (lgfs_pkg::PCT_W)'($urandom_range(0, 8));
		if (sel == 4)
			return (lgfs_pkg::PCT_W)'($urandom_range(101, 127));
		return (lgfs_pkg::PCT_W)'($urandom_range(0, 100));
	endfunction

	initial begin
		sb           = new();
		quiet        = 1'b0;
		n_tick       = 0;
		n_set_color  = 0;
		n_set_white  = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = lgfs_pkg::OP_TICK;
		color_mode   = lgfs_pkg::MODE_WHITE;
		red_target   = '0;
		green_target = '0;
		blue_target  = '0;
		white_level  = '0;
		white_temp   = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// tick straight out of reset, nothing to move
		send_tick();
		// full cool white, then retarget to full warm mid-fade in the same mode
		send_item(lgfs_pkg::OP_SET, lgfs_pkg::MODE_WHITE, 8'h00, 8'h00, 8'h00,
			7'd100, 7'd100);
		send_ticks(3);
		send_item(lgfs_pkg::OP_SET, lgfs_pkg::MODE_WHITE, 8'h00, 8'h00, 8'h00,
			7'd100, 7'd0);
		send_ticks(2);
		// both percents above the ceiling, then only the temperature
		send_item(lgfs_pkg::OP_SET, lgfs_pkg::MODE_WHITE, 8'hFF, 8'hFF, 8'hFF,
			7'd127, 7'd127);
		send_item(lgfs_pkg::OP_SET, lgfs_pkg::MODE_WHITE, 8'h00, 8'h00, 8'h00,
			7'd50, 7'd127);
		// colour mode: white group must ramp down before rgb moves
		send_item(lgfs_pkg::OP_SET, lgfs_pkg::MODE_COLOR, 8'hFF, 8'h00, 8'h80,
			7'd127, 7'd0);
		send_ticks(3);
		// colour retarget during the fade
		send_item(lgfs_pkg::OP_SET, lgfs_pkg::MODE_COLOR, 8'h00, 8'hFF, 8'h01,
			7'd0, 7'd100);
		send_ticks(2);
		// back to white, rgb group now the one turned off
		send_item(lgfs_pkg::OP_SET, lgfs_pkg::MODE_WHITE, 8'h55, 8'hAA, 8'h0F,
			7'd127, 7'd64);
		send_ticks(3);
		send_item(lgfs_pkg::OP_SET, lgfs_pkg::MODE_COLOR, 8'h00, 8'h00, 8'h00,
			7'd0, 7'd0);
		send_ticks(2);

		// random part: mostly ticks so fades run to their targets
		for (int unsigned k = 0; k < RAND_ITEMS; k++) begin
			if (k == QUIET_FROM)
				quiet = 1'b1;
			if ($urandom_range(0, 24) == 0)
				send_item(lgfs_pkg::OP_SET, lgfs_pkg::mode_t'($urandom_range(0, 1)),
					pick_target(), pick_target(), pick_target(), pick_pct(), pick_pct());
			else
				send_tick();
		end
		in_valid = 1'b0;

		// drain: wait for all owed reports, then keep watching for stray results
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d ticks, %0d colour sets and %0d white sets", n_tick,
			n_set_color, n_set_white);
		$display("%0d duty reports compared, %0d mismatches", sb.checked, sb.err_count);
		if (sb.err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
